// ----- rtl/tsbe_pkg.sv -----
`timescale 1ns / 1ps

package tsbe_pkg;

   // command codes
   localparam logic [3:0] ACT_PUT       = 4'd0;
   localparam logic [3:0] ACT_SET       = 4'd1;
   localparam logic [3:0] ACT_GOTO      = 4'd2;
   localparam logic [3:0] ACT_MOVE      = 4'd3;
   localparam logic [3:0] ACT_FILL      = 4'd4;
   localparam logic [3:0] ACT_SETATTR   = 4'd5;
   localparam logic [3:0] ACT_RESETATTR = 4'd6;
   localparam logic [3:0] ACT_READ      = 4'd7;
   localparam logic [3:0] ACT_POLL      = 4'd8;

   // register indexes
   localparam int         CSR_IDX_W   = 2;
   localparam logic [1:0] CSR_COLS    = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;
   localparam logic [1:0] CSR_DEF_FG  = 2'd2;
   localparam logic [1:0] CSR_DEF_BG  = 2'd3;

   localparam logic [7:0] COLS_RST    = 8'd80;
   localparam logic [6:0] ROWS_RST    = 7'd25;
   localparam logic [3:0] DEF_FG_RST  = 4'd7;
   localparam logic [3:0] DEF_BG_RST  = 4'd0;

   // attr layout: [11:8] bg, [7:4] fg, [3:0] style
   localparam logic [7:0]  BLANK_CHAR = 8'h20;
   localparam logic [11:0] RESET_ATTR = {DEF_BG_RST, DEF_FG_RST, 4'h0};

   typedef struct packed {
      logic clear;   // clearing pass writes one entry
      logic load;    // capture request word
      logic exec;    // decode and run the direct updates, issue cell read
      logic rmw;     // char write with change compare
      logic fill;    // write one fill cell
      logic finish;  // load result register
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_rmw;
      logic is_fill;
      logic fill_last;
   } sts_type;

endpackage

// ----- rtl/text_screen_buffer_engine.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Moves
// --------  --------------------------------------  ---------  ----------------------------
// req       req_valid/req_ready + 9 field ports     in         one command word
// rsp       rsp_valid/rsp_ready + 7 field ports     out        cursor, cell, changed flag
// csr       csr_valid/csr_ready, csr_index/wdata    in         one register write word
//
// From accept to the next accept: put and set pass exec, a read-compare-write state (on
// the single cell store port pair) and finish; fill passes exec, one fill state per cell
// of the rectangle (one cell store write a cycle) and finish; other commands exec and finish.
// Reset: a clearing pass writes blank cells over all MAX_COLS*MAX_ROWS entries before
// req_ready rises; csr writes are taken throughout.
// Stalls: a finished result sits in the output register while the next word is
// accepted; a second result waits in the controller until rsp_ready frees the register.

module text_screen_buffer_engine #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // command words
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_action,
   input  logic [7:0]                     req_char_code,
   input  logic signed [7:0]              req_col,
   input  logic signed [7:0]              req_row,
   input  logic [6:0]                     req_col_end,
   input  logic [5:0]                     req_row_end,
   input  logic signed [4:0]              req_style,
   input  logic signed [4:0]              req_fg_color,
   input  logic signed [4:0]              req_bg_color,
   // result words
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [6:0]                     rsp_cursor_col,
   output logic [5:0]                     rsp_cursor_row,
   output logic [7:0]                     rsp_cell_char,
   output logic [3:0]                     rsp_cell_style,
   output logic [3:0]                     rsp_cell_fg,
   output logic [3:0]                     rsp_cell_bg,
   output logic                           rsp_changed,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);

   tsbe_pkg::cmd_type cmd;
   tsbe_pkg::sts_type sts;

   // registers are always writable; writes land only while idle by contract
   assign csr_ready = 1'b1;

   // sequencer: clearing pass, then accept / execute / compare-write or fill / finish per command
   tsbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // cursor, attribute, changed flag, cell store and result register
   tsbe_dpath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_col_end    (req_col_end),
      .req_row_end    (req_row_end),
      .req_style      (req_style),
      .req_fg_color   (req_fg_color),
      .req_bg_color   (req_bg_color),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_style (rsp_cell_style),
      .rsp_cell_fg    (rsp_cell_fg),
      .rsp_cell_bg    (rsp_cell_bg),
      .rsp_changed    (rsp_changed)
   );

endmodule

// ----- rtl/tsbe_ctrl.sv -----
`timescale 1ns / 1ps

module tsbe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tsbe_pkg::cmd_type cmd,
   input  tsbe_pkg::sts_type sts
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_EXEC   = 6'b000100,
      ST_RMW    = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.load   = req_valid && (state_ff == ST_IDLE);
      cmd.exec   = (state_ff == ST_EXEC);
      cmd.rmw    = (state_ff == ST_RMW);
      cmd.fill   = (state_ff == ST_FILL);
      cmd.finish = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.is_rmw)       state_in = ST_RMW;
            else if (sts.is_fill) state_in = ST_FILL;
            else                  state_in = ST_FINISH;
         end
         ST_RMW: begin
            state_in = ST_FINISH;
         end
         ST_FILL: begin
            if (sts.fill_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/tsbe_dpath.sv -----
`timescale 1ns / 1ps

module tsbe_dpath #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tsbe_pkg::cmd_type                 cmd,
   output tsbe_pkg::sts_type                 sts,
   input  logic                              csr_we,
   input  logic [tsbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                        csr_wdata,
   input  logic [3:0]                        req_action,
   input  logic [7:0]                        req_char_code,
   input  logic signed [7:0]                 req_col,
   input  logic signed [7:0]                 req_row,
   input  logic [6:0]                        req_col_end,
   input  logic [5:0]                        req_row_end,
   input  logic signed [4:0]                 req_style,
   input  logic signed [4:0]                 req_fg_color,
   input  logic signed [4:0]                 req_bg_color,
   output logic [6:0]                        rsp_cursor_col,
   output logic [5:0]                        rsp_cursor_row,
   output logic [7:0]                        rsp_cell_char,
   output logic [3:0]                        rsp_cell_style,
   output logic [3:0]                        rsp_cell_fg,
   output logic [3:0]                        rsp_cell_bg,
   output logic                              rsp_changed
);

   localparam int XW    = $clog2(MAX_COLS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);

   // config
   logic [7:0]  cols_ff, cols_in;
   logic [6:0]  rows_ff, rows_in;
   logic [3:0]  dfg_ff, dfg_in, dbg_ff, dbg_in;
   logic [CW-1:0] eff_cols;
   logic [RW-1:0] eff_rows;
   logic [XW-1:0] last_x;
   logic [YW-1:0] last_y;

   // latched request
   logic [3:0]        act_ff;
   logic [7:0]        char_ff;
   logic signed [7:0] col_ff, row_ff;
   logic [6:0]        col_end_ff;
   logic [5:0]        row_end_ff;
   logic signed [4:0] style_ff, fg_ff, bg_ff;

   // state
   logic [XW-1:0] cur_x_ff, cur_x_in;
   logic [YW-1:0] cur_y_ff, cur_y_in;
   logic [11:0]   attr_ff, attr_in;
   logic          dirty_ff, dirty_in;
   logic [AW-1:0] clr_ff;

   // fill walk
   logic [XW-1:0] fx_ff, fx_in, x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic [YW-1:0] fy_ff, fy_in, y_hi_ff, y_hi_in;

   // result staging
   logic chg_ff, chg_in, cell_sel_ff, cell_sel_in;

   // cell store: [19:12] char, [11:0] attr
   logic [19:0]   cell_mem [CELLS];
   logic [19:0]   rdata_ff;
   logic          mem_we;
   logic [AW-1:0] waddr, raddr, cur_addr, fill_addr, read_addr;
   logic [19:0]   wdata;

   // ---------------- config and effective size ----------------
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      dfg_in  = dfg_ff;
      dbg_in  = dbg_ff;
      if (csr_we) begin
         case (csr_index)
            tsbe_pkg::CSR_COLS:   cols_in = csr_wdata;
            tsbe_pkg::CSR_ROWS:   rows_in = csr_wdata[6:0];
            tsbe_pkg::CSR_DEF_FG: dfg_in  = csr_wdata[3:0];
            tsbe_pkg::CSR_DEF_BG: dbg_in  = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cols_in == 8'd0)                     eff_cols = CW'(1);
      else if (9'(cols_in) > 9'(MAX_COLS))     eff_cols = CW'(MAX_COLS);
      else                                     eff_cols = CW'(cols_in);
      if (rows_in == 7'd0)                     eff_rows = RW'(1);
      else if (9'(rows_in) > 9'(MAX_ROWS))     eff_rows = RW'(MAX_ROWS);
      else                                     eff_rows = RW'(rows_in);
   end

   assign last_x = XW'(eff_cols - CW'(1));
   assign last_y = YW'(eff_rows - RW'(1));

   // ---------------- goto / move arithmetic ----------------
   logic signed [9:0] xb, xd, xs, xlast_s, yb, yd, ys, ylast_s;
   logic [XW-1:0]     x_clamp;
   logic [YW-1:0]     y_clamp;

   always_comb begin
      xb = 10'(cur_x_ff);
      xd = 10'(col_ff);
      yb = 10'(cur_y_ff);
      yd = 10'(row_ff);
      if (act_ff == tsbe_pkg::ACT_GOTO) begin
         // negative target keeps the axis
         if (col_ff[7]) xd = '0;
         else           xb = '0;
         if (row_ff[7]) yd = '0;
         else           yb = '0;
      end
      xs      = xb + xd;
      ys      = yb + yd;
      xlast_s = 10'(last_x);
      ylast_s = 10'(last_y);
      if (xs < 0)            x_clamp = '0;
      else if (xs > xlast_s) x_clamp = last_x;
      else                   x_clamp = XW'(xs);
      if (ys < 0)            y_clamp = '0;
      else if (ys > ylast_s) y_clamp = last_y;
      else                   y_clamp = YW'(ys);
   end

   // ---------------- fill bounds ----------------
   logic [7:0]    fa_x, fb_x, lo_x, hi_x, fa_y, fb_y, lo_y, hi_y;
   logic [XW-1:0] lo_xc, hi_xc;
   logic [YW-1:0] lo_yc, hi_yc;

   always_comb begin
      fa_x = unsigned'(col_ff);
      fb_x = 8'(col_end_ff);
      fa_y = unsigned'(row_ff);
      fb_y = 8'(row_end_ff);
      lo_x = (fa_x > fb_x) ? fb_x : fa_x;
      hi_x = (fa_x > fb_x) ? fa_x : fb_x;
      lo_y = (fa_y > fb_y) ? fb_y : fa_y;
      hi_y = (fa_y > fb_y) ? fa_y : fb_y;
      lo_xc = (9'(lo_x) >= 9'(eff_cols)) ? last_x : XW'(lo_x);
      hi_xc = (9'(hi_x) >= 9'(eff_cols)) ? last_x : XW'(hi_x);
      lo_yc = (9'(lo_y) >= 9'(eff_rows)) ? last_y : YW'(lo_y);
      hi_yc = (9'(hi_y) >= 9'(eff_rows)) ? last_y : YW'(hi_y);
   end

   // ---------------- addresses ----------------
   logic in_range;

   assign in_range  = (9'(unsigned'(col_ff)) < 9'(eff_cols)) &&
                      (9'(unsigned'(row_ff)) < 9'(eff_rows));
   assign cur_addr  = AW'(cur_y_ff) * AW'(MAX_COLS) + AW'(cur_x_ff);
   assign fill_addr = AW'(fy_ff) * AW'(MAX_COLS) + AW'(fx_ff);
   // part-selects are unsigned, so the coordinates zero-extend
   assign read_addr = AW'(row_ff[YW-1:0]) * AW'(MAX_COLS) + AW'(col_ff[XW-1:0]);

   // ---------------- state update ----------------
   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      attr_in     = attr_ff;
      dirty_in    = dirty_ff;
      fx_in       = fx_ff;
      fy_in       = fy_ff;
      x_lo_in     = x_lo_ff;
      x_hi_in     = x_hi_ff;
      y_hi_in     = y_hi_ff;
      chg_in      = chg_ff;
      cell_sel_in = cell_sel_ff;

      // size change pulls the cursor into the new area
      if (csr_we) begin
         if (cur_x_ff > last_x) cur_x_in = last_x;
         if (cur_y_ff > last_y) cur_y_in = last_y;
      end

      if (cmd.exec) begin
         chg_in      = 1'b0;
         cell_sel_in = (act_ff == tsbe_pkg::ACT_READ) && in_range;
         case (act_ff)
            tsbe_pkg::ACT_GOTO, tsbe_pkg::ACT_MOVE: begin
               cur_x_in = x_clamp;
               cur_y_in = y_clamp;
            end
            tsbe_pkg::ACT_FILL: begin
               fx_in   = lo_xc;
               fy_in   = lo_yc;
               x_lo_in = lo_xc;
               x_hi_in = hi_xc;
               y_hi_in = hi_yc;
            end
            tsbe_pkg::ACT_SETATTR: begin
               if (!style_ff[4]) attr_in[3:0]  = style_ff[3:0];
               if (!fg_ff[4])    attr_in[7:4]  = fg_ff[3:0];
               if (!bg_ff[4])    attr_in[11:8] = bg_ff[3:0];
            end
            tsbe_pkg::ACT_RESETATTR: begin
               attr_in = {dbg_ff, dfg_ff, 4'h0};
            end
            tsbe_pkg::ACT_POLL: begin
               chg_in   = dirty_ff;
               dirty_in = 1'b0;
            end
            default: ;
         endcase
      end

      if (cmd.rmw) begin
         if (rdata_ff[19:12] != char_ff) dirty_in = 1'b1;
         if (act_ff == tsbe_pkg::ACT_PUT) begin
            if (cur_x_ff >= last_x) begin
               cur_x_in = '0;
               if (cur_y_ff < last_y) cur_y_in = cur_y_ff + YW'(1);
            end else begin
               cur_x_in = cur_x_ff + XW'(1);
            end
         end
      end

      if (cmd.fill) begin
         if (fx_ff == x_hi_ff) begin
            fx_in = x_lo_ff;
            fy_in = fy_ff + YW'(1);
         end else begin
            fx_in = fx_ff + XW'(1);
         end
      end
   end

   always_comb begin
      sts            = '0;
      sts.clear_last = (clr_ff == AW'(CELLS - 1));
      sts.is_rmw     = (act_ff == tsbe_pkg::ACT_PUT) || (act_ff == tsbe_pkg::ACT_SET);
      sts.is_fill    = (act_ff == tsbe_pkg::ACT_FILL);
      sts.fill_last  = (fx_ff == x_hi_ff) && (fy_ff == y_hi_ff);
   end

   // ---------------- cell store ----------------
   always_comb begin
      mem_we = cmd.clear || cmd.rmw || cmd.fill;
      raddr  = (act_ff == tsbe_pkg::ACT_READ) ? read_addr : cur_addr;
      if (cmd.clear) begin
         waddr = clr_ff;
         wdata = {tsbe_pkg::BLANK_CHAR, tsbe_pkg::RESET_ATTR};
      end else begin
         waddr = cmd.rmw ? cur_addr : fill_addr;
         wdata = {char_ff, attr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[waddr] <= wdata;
      if (cmd.exec) rdata_ff <= cell_mem[raddr];
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= tsbe_pkg::COLS_RST;
         rows_ff  <= tsbe_pkg::ROWS_RST;
         dfg_ff   <= tsbe_pkg::DEF_FG_RST;
         dbg_ff   <= tsbe_pkg::DEF_BG_RST;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         attr_ff  <= tsbe_pkg::RESET_ATTR;
         dirty_ff <= 1'b1;
         clr_ff   <= '0;
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         dfg_ff   <= dfg_in;
         dbg_ff   <= dbg_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         attr_ff  <= attr_in;
         dirty_ff <= dirty_in;
         if (cmd.clear) clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff     <= req_action;
         char_ff    <= req_char_code;
         col_ff     <= req_col;
         row_ff     <= req_row;
         col_end_ff <= req_col_end;
         row_end_ff <= req_row_end;
         style_ff   <= req_style;
         fg_ff      <= req_fg_color;
         bg_ff      <= req_bg_color;
      end
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      x_lo_ff     <= x_lo_in;
      x_hi_ff     <= x_hi_in;
      y_hi_ff     <= y_hi_in;
      chg_ff      <= chg_in;
      cell_sel_ff <= cell_sel_in;
      if (cmd.finish) begin
         rsp_cursor_col <= 7'(cur_x_ff);
         rsp_cursor_row <= 6'(cur_y_ff);
         rsp_cell_char  <= cell_sel_ff ? rdata_ff[19:12] : 8'd0;
         rsp_cell_style <= cell_sel_ff ? rdata_ff[3:0]   : 4'd0;
         rsp_cell_fg    <= cell_sel_ff ? rdata_ff[7:4]   : 4'd0;
         rsp_cell_bg    <= cell_sel_ff ? rdata_ff[11:8]  : 4'd0;
         rsp_changed    <= chg_ff;
      end
   end

endmodule

// ----- sim/tb_text_screen_buffer_engine.sv -----
`timescale 1ns / 1ps

module tb_text_screen_buffer_engine;

   // Screen store geometry, matching the block's default parameters.
   localparam int COLS_MAX   = 128;
   localparam int ROWS_MAX   = 64;
   localparam int CELL_COUNT = COLS_MAX * ROWS_MAX;

   // Commands above ACT_POLL are undefined: they must leave the state alone.
   localparam logic [3:0] ACT_UNDEF_LO = tsbe_pkg::ACT_POLL + 4'd1;
   localparam logic [3:0] ACT_UNDEF_HI = 4'hF;

   // One command word as it goes out on the req channel.
   typedef struct packed {
      logic [3:0]        action;
      logic [7:0]        ch;
      logic signed [7:0] col;
      logic signed [7:0] row;
      logic [6:0]        col_end;
      logic [5:0]        row_end;
      logic signed [4:0] style;
      logic signed [4:0] fg;
      logic signed [4:0] bg;
   } cmd_word_type;

   localparam int CMD_BITS = $bits(cmd_word_type);

   // One result word: cursor after the command plus the cell or the changed flag.
   typedef struct packed {
      logic [6:0] cur_col;
      logic [5:0] cur_row;
      logic [7:0] ch;
      logic [3:0] style;
      logic [3:0] fg;
      logic [3:0] bg;
      logic       changed;
   } view_word_type;

   // ---------------------------------------------------------------
   // DUT ports; every input starts at a known value
   // ---------------------------------------------------------------
   logic                            clock;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic                            req_ready;
   logic [3:0]                      req_action    = '0;
   logic [7:0]                      req_char_code = '0;
   logic signed [7:0]               req_col       = '0;
   logic signed [7:0]               req_row       = '0;
   logic [6:0]                      req_col_end   = '0;
   logic [5:0]                      req_row_end   = '0;
   logic signed [4:0]               req_style     = '0;
   logic signed [4:0]               req_fg_color  = '0;
   logic signed [4:0]               req_bg_color  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready     = 1'b0;
   logic [6:0]                      rsp_cursor_col;
   logic [5:0]                      rsp_cursor_row;
   logic [7:0]                      rsp_cell_char;
   logic [3:0]                      rsp_cell_style;
   logic [3:0]                      rsp_cell_fg;
   logic [3:0]                      rsp_cell_bg;
   logic                            rsp_changed;
   logic                            csr_valid     = 1'b0;
   logic                            csr_ready;
   logic [tsbe_pkg::CSR_IDX_W-1:0]  csr_index     = '0;
   logic [7:0]                      csr_wdata     = '0;

   text_screen_buffer_engine u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_char_code (req_char_code),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_col_end   (req_col_end),
      .req_row_end   (req_row_end),
      .req_style     (req_style),
      .req_fg_color  (req_fg_color),
      .req_bg_color  (req_bg_color),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_char (rsp_cell_char),
      .rsp_cell_style(rsp_cell_style),
      .rsp_cell_fg   (rsp_cell_fg),
      .rsp_cell_bg   (rsp_cell_bg),
      .rsp_changed   (rsp_changed),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Shadow copy of the screen: cells, cursor, pen attribute, registers
   // ---------------------------------------------------------------
   logic [7:0]  shadow_chars [CELL_COUNT];
   logic [11:0] shadow_attrs [CELL_COUNT];   // [11:8] bg, [7:4] fg, [3:0] style
   int unsigned cur_x, cur_y;
   logic [11:0] pen_attr;
   bit          screen_dirty;
   logic [7:0]  reg_cols;
   logic [6:0]  reg_rows;
   logic [3:0]  reg_fg, reg_bg;

   view_word_type views_due [$];   // results owed by the block, oldest first
   int          err_count      = 0;
   bit          gaps_on        = 1'b1;
   bit          stalls_on      = 1'b1;
   int          big_fills_left = 8;  // caps the slow full-size fills
   int          stall_left     = 0;

   function automatic void screen_reset();
      int i;
      reg_cols = tsbe_pkg::COLS_RST;
      reg_rows = tsbe_pkg::ROWS_RST;
      reg_fg   = tsbe_pkg::DEF_FG_RST;
      reg_bg   = tsbe_pkg::DEF_BG_RST;
      pen_attr = {reg_bg, reg_fg, 4'h0};
      for (i = 0; i < CELL_COUNT; i++) begin
         shadow_chars[i] = tsbe_pkg::BLANK_CHAR;
         shadow_attrs[i] = pen_attr;
      end
      cur_x        = 0;
      cur_y        = 0;
      screen_dirty = 1'b1;
   endfunction

   // A width of 0 acts as 1, anything past the store acts as the store size.
   function automatic int unsigned width_now();
      int unsigned w;
      w = 32'(reg_cols);
      if (w < 1) w = 1;
      if (w > COLS_MAX) w = COLS_MAX;
      return w;
   endfunction

   function automatic int unsigned height_now();
      int unsigned h;
      h = 32'(reg_rows);
      if (h < 1) h = 1;
      if (h > ROWS_MAX) h = ROWS_MAX;
      return h;
   endfunction

   function automatic void fit_cursor();
      if (cur_x >= width_now()) cur_x = width_now() - 1;
      if (cur_y >= height_now()) cur_y = height_now() - 1;
   endfunction

   // Applies one accepted command to the shadow screen and returns the word
   // the block owes for it.
   function automatic view_word_type apply_command(cmd_word_type c);
      view_word_type v;
      int unsigned   w, h, x1, x2, y1, y2, t, idx, xx, yy;
      int            dx, dy, nx, ny;
      w  = width_now();
      h  = height_now();
      v  = '0;
      x1 = {24'd0, c.col};   // fill corners and read address are unsigned
      y1 = {24'd0, c.row};
      dx = $signed(c.col);
      dy = $signed(c.row);
      case (c.action)
         tsbe_pkg::ACT_PUT, tsbe_pkg::ACT_SET: begin
            idx = cur_y * COLS_MAX + cur_x;
            // only a different char marks the screen changed
            if (shadow_chars[idx] != c.ch) screen_dirty = 1'b1;
            shadow_chars[idx] = c.ch;
            shadow_attrs[idx] = pen_attr;
            if (c.action == tsbe_pkg::ACT_PUT) begin
               cur_x++;
               if (cur_x >= w) begin
                  cur_x = 0;
                  if (cur_y + 1 < h) cur_y++;   // last row: no scroll
               end
            end
         end
         tsbe_pkg::ACT_GOTO: begin
            if (dx >= 0) cur_x = dx;
            if (dy >= 0) cur_y = dy;
            fit_cursor();
         end
         tsbe_pkg::ACT_MOVE: begin
            nx = int'(cur_x) + dx;
            ny = int'(cur_y) + dy;
            if (nx < 0) nx = 0;
            if (nx >= int'(w)) nx = int'(w) - 1;
            if (ny < 0) ny = 0;
            if (ny >= int'(h)) ny = int'(h) - 1;
            cur_x = nx;
            cur_y = ny;
         end
         tsbe_pkg::ACT_FILL: begin
            x2 = 32'(c.col_end);
            y2 = 32'(c.row_end);
            if (x1 > x2) begin
               t = x1; x1 = x2; x2 = t;
            end
            if (y1 > y2) begin
               t = y1; y1 = y2; y2 = t;
            end
            if (x1 >= w) x1 = w - 1;
            if (x2 >= w) x2 = w - 1;
            if (y1 >= h) y1 = h - 1;
            if (y2 >= h) y2 = h - 1;
            // fills never touch the changed flag
            for (yy = y1; yy <= y2; yy++) begin
               for (xx = x1; xx <= x2; xx++) begin
                  shadow_chars[yy * COLS_MAX + xx] = c.ch;
                  shadow_attrs[yy * COLS_MAX + xx] = pen_attr;
               end
            end
         end
         tsbe_pkg::ACT_SETATTR: begin
            // a negative value keeps that part of the pen
            if (!c.style[4]) pen_attr[3:0]  = c.style[3:0];
            if (!c.fg[4])    pen_attr[7:4]  = c.fg[3:0];
            if (!c.bg[4])    pen_attr[11:8] = c.bg[3:0];
         end
         tsbe_pkg::ACT_RESETATTR: pen_attr = {reg_bg, reg_fg, 4'h0};
         tsbe_pkg::ACT_READ: begin
            // off-screen cells read as all zero
            if (x1 < w && y1 < h) begin
               idx     = y1 * COLS_MAX + x1;
               v.ch    = shadow_chars[idx];
               v.style = shadow_attrs[idx][3:0];
               v.fg    = shadow_attrs[idx][7:4];
               v.bg    = shadow_attrs[idx][11:8];
            end
         end
         tsbe_pkg::ACT_POLL: begin
            v.changed    = screen_dirty;
            screen_dirty = 1'b0;
         end
         default: ;
      endcase
      v.cur_col = 7'(cur_x);
      v.cur_row = 6'(cur_y);
      return v;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic cmd_word_type mk_cmd(logic [3:0] act, int ch = 0, int col = 0,
                                           int row = 0, int col_end = 0, int row_end = 0,
                                           int st = 0, int fg = 0, int bg = 0);
      cmd_word_type c;
      c.action  = act;
      c.ch      = 8'(ch);
      c.col     = 8'(col);
      c.row     = 8'(row);
      c.col_end = 7'(col_end);
      c.row_end = 6'(row_end);
      c.style   = 5'(st);
      c.fg      = 5'(fg);
      c.bg      = 5'(bg);
      return c;
   endfunction

   // Random word shaped toward the live screen area; unused fields stay random.
   function automatic cmd_word_type random_cmd();
      cmd_word_type c;
      int unsigned  w, h, pick, x, y, lo, hi;
      w    = width_now();
      h    = height_now();
      c    = CMD_BITS'({$urandom(), $urandom()});
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         c.action = tsbe_pkg::ACT_PUT;
         // lots of repeated chars so that writes often leave the flag alone
         if ($urandom_range(0, 1) == 0)
            c.ch = 8'(tsbe_pkg::BLANK_CHAR + $urandom_range(0, 2));
      end else if (pick < 38) begin
         c.action = tsbe_pkg::ACT_SET;
         if ($urandom_range(0, 1) == 0)
            c.ch = 8'(tsbe_pkg::BLANK_CHAR + $urandom_range(0, 2));
      end else if (pick < 48) begin
         c.action = tsbe_pkg::ACT_GOTO;
         if ($urandom_range(0, 4) != 0) begin
            c.col = 8'($urandom_range(0, w - 1));
            c.row = 8'($urandom_range(0, h - 1));
         end
      end else if (pick < 58) begin
         c.action = tsbe_pkg::ACT_MOVE;
         if ($urandom_range(0, 9) != 0) begin
            c.col = 8'(int'($urandom_range(0, 6)) - 3);
            c.row = 8'(int'($urandom_range(0, 6)) - 3);
         end
      end else if (pick < 65) begin
         c.action = tsbe_pkg::ACT_FILL;
         if (big_fills_left > 0 && $urandom_range(0, 19) == 0) begin
            big_fills_left--;   // keep the fully random corners
         end else begin
            x  = $urandom_range(0, w - 1);
            lo = (x > 6) ? x - 6 : 0;
            hi = (x + 6 > 127) ? 127 : x + 6;
            c.col     = 8'(x);
            c.col_end = 7'($urandom_range(lo, hi));
            y  = $urandom_range(0, h - 1);
            lo = (y > 3) ? y - 3 : 0;
            hi = (y + 3 > 63) ? 63 : y + 3;
            c.row     = 8'(y);
            c.row_end = 6'($urandom_range(lo, hi));
         end
      end else if (pick < 72) begin
         c.action = tsbe_pkg::ACT_SETATTR;
      end else if (pick < 75) begin
         c.action = tsbe_pkg::ACT_RESETATTR;
      end else if (pick < 90) begin
         c.action = tsbe_pkg::ACT_READ;
         if ($urandom_range(0, 9) < 7) begin
            c.col = 8'($urandom_range(0, w - 1));
            c.row = 8'($urandom_range(0, h - 1));
         end
      end else if (pick < 96) begin
         c.action = tsbe_pkg::ACT_POLL;
      end else begin
         c.action = 4'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
      end
      return c;
   endfunction

   // Sends one command word. Valid is left high after the accept so that a
   // back-to-back word needs only one assignment per step.
   task automatic send_cmd(input cmd_word_type c);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= c.action;
      req_char_code <= c.ch;
      req_col       <= c.col;
      req_row       <= c.row;
      req_col_end   <= c.col_end;
      req_row_end   <= c.row_end;
      req_style     <= c.style;
      req_fg_color  <= c.fg;
      req_bg_color  <= c.bg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      views_due.push_back(apply_command(c));
   endtask

   // Holds the sender until the block has returned everything it owes.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (views_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tsbe_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tsbe_pkg::CSR_COLS: begin
            reg_cols = val;
            fit_cursor();
         end
         tsbe_pkg::CSR_ROWS: begin
            reg_rows = val[6:0];
            fit_cursor();
         end
         tsbe_pkg::CSR_DEF_FG: reg_fg = val[3:0];
         tsbe_pkg::CSR_DEF_BG: reg_bg = val[3:0];
         default: ;
      endcase
   endtask

   // All four registers, written only once the block is idle. Upper data
   // bits of the colour words are junk the block must drop.
   task automatic apply_regs(input logic [7:0] cols, input logic [7:0] rows,
                             input logic [3:0] fg, input logic [3:0] bg);
      drain_results();
      write_reg(tsbe_pkg::CSR_COLS, cols);
      write_reg(tsbe_pkg::CSR_ROWS, rows);
      write_reg(tsbe_pkg::CSR_DEF_FG, {4'($urandom()), fg});
      write_reg(tsbe_pkg::CSR_DEF_BG, {4'($urandom()), bg});
      csr_valid <= 1'b0;
   endtask

   // Random words, with runs of puts now and then like a line of text.
   task automatic random_burst(input int n);
      int           sent;
      int           run;
      cmd_word_type c;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(4, 24);
            repeat (run) begin
               c        = random_cmd();
               c.action = tsbe_pkg::ACT_PUT;
               send_cmd(c);
               sent++;
            end
         end else begin
            send_cmd(random_cmd());
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Result side: random stall bursts on rsp_ready, and the checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 19);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string msg);
      err_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Outputs are sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      view_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (views_due.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
         end else begin
            want = views_due.pop_front();
            check_field("cursor_col", 8'(rsp_cursor_col), 8'(want.cur_col));
            check_field("cursor_row", 8'(rsp_cursor_row), 8'(want.cur_row));
            check_field("cell_char", rsp_cell_char, want.ch);
            check_field("cell_style", 8'(rsp_cell_style), 8'(want.style));
            check_field("cell_fg", 8'(rsp_cell_fg), 8'(want.fg));
            check_field("cell_bg", 8'(rsp_cell_bg), 8'(want.bg));
            check_field("changed", 8'(rsp_changed), 8'(want.changed));
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Corner cases at the reset geometry (80 x 25).
   task automatic test_directed();
      send_cmd(mk_cmd(tsbe_pkg::ACT_POLL));              // flag is set out of reset
      send_cmd(mk_cmd(tsbe_pkg::ACT_POLL));              // and now clear
      send_cmd(mk_cmd(tsbe_pkg::ACT_READ, 0, 0, 0));     // blank cell, normal attribute
      send_cmd(mk_cmd(tsbe_pkg::ACT_SET, int'(tsbe_pkg::BLANK_CHAR)));   // no change
      send_cmd(mk_cmd(tsbe_pkg::ACT_PUT, 8'hFF));
      send_cmd(mk_cmd(tsbe_pkg::ACT_PUT, 8'h00));
      send_cmd(mk_cmd(tsbe_pkg::ACT_POLL));
      send_cmd(mk_cmd(tsbe_pkg::ACT_GOTO, 0, 79, 24));
      send_cmd(mk_cmd(tsbe_pkg::ACT_PUT, 8'h41));        // wrap on the last row, no scroll
      send_cmd(mk_cmd(tsbe_pkg::ACT_GOTO, 0, -1, -128)); // negative keeps both axes
      send_cmd(mk_cmd(tsbe_pkg::ACT_GOTO, 0, 127, 127)); // clamps to the last cell
      send_cmd(mk_cmd(tsbe_pkg::ACT_MOVE, 0, -128, -128));
      send_cmd(mk_cmd(tsbe_pkg::ACT_MOVE, 0, 127, 127));
      send_cmd(mk_cmd(tsbe_pkg::ACT_SETATTR, 0, 0, 0, 0, 0, 15, 15, 15));
      send_cmd(mk_cmd(tsbe_pkg::ACT_SETATTR, 0, 0, 0, 0, 0, -1, -16, 0));
      send_cmd(mk_cmd(tsbe_pkg::ACT_SET, 8'h5A));
      send_cmd(mk_cmd(tsbe_pkg::ACT_READ, 0, 79, 24));
      send_cmd(mk_cmd(tsbe_pkg::ACT_RESETATTR));
      send_cmd(mk_cmd(tsbe_pkg::ACT_POLL));
      // corners out of order and past the screen: both rows clamp, last row filled
      send_cmd(mk_cmd(tsbe_pkg::ACT_FILL, 8'h23, -1, -1, 0, 63));
      send_cmd(mk_cmd(tsbe_pkg::ACT_POLL));              // fill leaves the flag clear
      send_cmd(mk_cmd(tsbe_pkg::ACT_FILL, 8'h78, 5, 3, 2, 1));
      send_cmd(mk_cmd(tsbe_pkg::ACT_READ, 0, 3, 2));
      send_cmd(mk_cmd(tsbe_pkg::ACT_READ, 0, -1, -1));   // off screen reads zero
      send_cmd(mk_cmd(tsbe_pkg::ACT_READ, 0, 80, 0));
      send_cmd(mk_cmd(ACT_UNDEF_LO, 8'hFF, 1, 1, 127, 63, 15, 15, 15));
      send_cmd(mk_cmd(ACT_UNDEF_HI, 8'hFF, -1, -1, 127, 63, -16, -16, -16));
   endtask

   task automatic test_random_defaults();
      random_burst(400);
   endtask

   // Geometry sweep: 1x1, zero sizes, oversize values, full store, odd sizes.
   // The cursor is parked far out first so that a write that shrinks the area has to clamp it.
   task automatic test_screen_sizes();
      logic [7:0] size_cols [7] = '{8'd1, 8'd0, 8'd255, 8'd128, 8'd2, 8'd127, 8'd40};
      logic [7:0] size_rows [7] = '{8'd1, 8'd128, 8'd127, 8'd64, 8'd2, 8'd63, 8'd10};
      int         i;
      for (i = 0; i < 7; i++) begin
         send_cmd(mk_cmd(tsbe_pkg::ACT_GOTO, 0, 127, 127));
         apply_regs(size_cols[i], size_rows[i], 4'($urandom()), 4'($urandom()));
         send_cmd(mk_cmd(tsbe_pkg::ACT_PUT, 8'h41));
         send_cmd(mk_cmd(tsbe_pkg::ACT_PUT, 8'h42));
         send_cmd(mk_cmd(tsbe_pkg::ACT_READ, 0, 0, 0));
         send_cmd(mk_cmd(tsbe_pkg::ACT_POLL));
         random_burst(110);
      end
   endtask

   // Normal attribute taken from the colour registers at resetattr time.
   task automatic test_default_colors();
      logic [3:0] fg_set [4] = '{4'd0, 4'd15, 4'd15, 4'd0};
      logic [3:0] bg_set [4] = '{4'd0, 4'd15, 4'd0, 4'd15};
      int         i;
      for (i = 0; i < 4; i++) begin
         apply_regs(tsbe_pkg::COLS_RST, 8'(tsbe_pkg::ROWS_RST), fg_set[i], bg_set[i]);
         send_cmd(mk_cmd(tsbe_pkg::ACT_RESETATTR));
         send_cmd(mk_cmd(tsbe_pkg::ACT_SET, 8'h7E));
         send_cmd(mk_cmd(tsbe_pkg::ACT_READ, 0, -128, -128));   // off screen
         random_burst(40);
      end
   endtask

   // Last stretch: both sides at full rate.
   task automatic test_full_throttle();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      random_burst(200);
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      screen_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_defaults();
      test_screen_sizes();
      test_default_colors();
      test_full_throttle();
      drain_results();
      repeat (20) @(posedge clock);   // nothing more may come out
      if (err_count == 0) begin
         $display("[text_screen_buffer_engine] OK");
      end else begin
         $display("[text_screen_buffer_engine] ERROR");
      end
      $finish;
   end

   // Watchdog: covers the clearing pass, capped full-size fills and every stall.
   initial begin
      #10_000_000;
      $display("[text_screen_buffer_engine] ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tsbe_pkg.sv
rtl/tsbe_ctrl.sv
rtl/tsbe_dpath.sv
rtl/text_screen_buffer_engine.sv
sim/tb_text_screen_buffer_engine.sv
